// ===== hw/rtl/lcdfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Shared types, command codes and helpers of the memory LCD frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdfb_pkg;

	// Field widths bounded by the largest supported panel (496 x 255)
	localparam int unsigned ROW_MAX_W  = 8;
	localparam int unsigned COL_MAX_W  = 6;
	localparam int unsigned ADDR_MAX_W = 14;

	// Link protocol bytes
	localparam logic [7:0] BYTE_BEGIN_WRITE = 8'h01;
	localparam logic [7:0] BYTE_CLEAR       = 8'h04;
	localparam logic [7:0] BYTE_TRAILER     = 8'h00;
	localparam logic [7:0] BYTE_BLANK       = 8'hFF;

	// Result kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_LINK  = 1'b1;

	typedef enum logic [2:0] {
		CMD_WRITE_PIXEL   = 3'd0,
		CMD_READ_PIXEL    = 3'd1,
		CMD_FILL          = 3'd2,
		CMD_CLEAR_DISPLAY = 3'd3,
		CMD_BEGIN_WRITE   = 3'd4,
		CMD_SEND_LINE     = 3'd5,
		CMD_END_WRITE     = 3'd6
	} command_t;

	// Input item as seen on the command channel
	typedef struct packed {
		logic [2:0] command;
		logic [9:0] x_pos;
		logic [9:0] y_pos;
		logic       pixel_value;
	} cmd_item_t;

	// Result item as seen on the result channel
	typedef struct packed {
		logic       result_kind;
		logic [7:0] out_byte;
		logic       read_pixel_value;
		logic       last;
	} result_item_t;

	// Classified operation passed from the front end to the back end
	typedef struct packed {
		command_t              command;
		logic                  in_range;
		logic [ROW_MAX_W-1:0]  row;
		logic [COL_MAX_W-1:0]  col;
		logic [2:0]            bit_idx;
		logic                  value;
		logic [ADDR_MAX_W-1:0] base;
	} op_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_MERGE,
		ST_ROW_INIT,
		ST_READ_EMIT,
		ST_CLEAR_TAIL,
		ST_LINE_READ,
		ST_LINE_EMIT,
		ST_LINE_TAIL
	} back_state_t;

	// Set or clear one bit of a byte
	function automatic logic [7:0] merge_bit(input logic [7:0] data_byte,
		input logic [2:0] idx, input logic value);
		logic [7:0] res;
		res      = data_byte;
		res[idx] = value;
		return res;
	endfunction

	function automatic result_item_t make_result(input logic kind,
		input logic [7:0] data_byte, input logic pix, input logic is_last);
		result_item_t r;
		r.result_kind      = kind;
		r.out_byte         = data_byte;
		r.read_pixel_value = pix;
		r.last             = is_last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcdfb_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcdfb_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdfb_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcdfb_front.sv =====
// ----------------------------------------------------------------------------
// lcdfb_front
// Takes commands, checks ranges, computes the row base and queues operations.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_front #(
	parameter int unsigned WIDTH_PIXELS,
	parameter int unsigned HEIGHT_LINES
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	lcdfb_stream_if.sink                 cmd,
	output lcdfb_pkg::op_t               push_op,
	output logic                         push,
	input  wire lcdfb_pkg::queue_status_t q_status
);

	localparam int unsigned BPL = WIDTH_PIXELS / 8;
	localparam logic [9:0] W_LIM   = 10'(WIDTH_PIXELS);
	localparam logic [9:0] H_LIM   = 10'(HEIGHT_LINES);
	localparam logic [6:0] BPL_LIM = 7'(BPL);

	lcdfb_pkg::cmd_item_t item_s1;
	logic                 valid_s1;
	logic                 keep;
	logic                 consume;
	logic                 x_ok;
	logic                 y_ok;

	// Classify the registered command
	always_comb begin
		x_ok = (item_s1.x_pos < W_LIM) && (item_s1.x_pos[9:3] < BPL_LIM);
		y_ok = item_s1.y_pos < H_LIM;
		push_op.command  = lcdfb_pkg::command_t'(item_s1.command);
		push_op.in_range = x_ok && y_ok;
		push_op.row      = item_s1.y_pos[7:0];
		push_op.col      = item_s1.x_pos[8:3];
		push_op.bit_idx  = item_s1.x_pos[2:0];
		push_op.value    = item_s1.pixel_value;
		push_op.base     = lcdfb_pkg::ADDR_MAX_W'(item_s1.y_pos[7:0]) *
			lcdfb_pkg::ADDR_MAX_W'(BPL);
		unique case (item_s1.command)
			lcdfb_pkg::CMD_WRITE_PIXEL:   keep = x_ok && y_ok;
			lcdfb_pkg::CMD_READ_PIXEL:    keep = 1'b1;
			lcdfb_pkg::CMD_FILL:          keep = 1'b1;
			lcdfb_pkg::CMD_CLEAR_DISPLAY: keep = 1'b1;
			lcdfb_pkg::CMD_BEGIN_WRITE:   keep = 1'b1;
			lcdfb_pkg::CMD_SEND_LINE:     keep = y_ok;
			lcdfb_pkg::CMD_END_WRITE:     keep = 1'b1;
			default:                      keep = 1'b0;
		endcase
	end

	// Dropped commands leave at once; kept ones wait for queue space
	assign consume   = valid_s1 && (!keep || !q_status.full);
	assign push      = valid_s1 && keep && !q_status.full;
	assign cmd.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdfb_queue.sv =====
// ----------------------------------------------------------------------------
// lcdfb_queue
// Two-entry operation queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lcdfb_pkg::op_t push_op,
	input  wire logic           pop,
	output lcdfb_pkg::op_t      head,
	output lcdfb_pkg::queue_status_t status
);

	lcdfb_pkg::op_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head             = entry_q[rd_ptr_q];
	assign status.not_empty = count_q != 2'd0;
	assign status.full      = count_q == 2'd2;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdfb_back.sv =====
// ----------------------------------------------------------------------------
// lcdfb_back
// Executes queued operations on the frame memory and drives the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_back #(
	parameter int unsigned WIDTH_PIXELS,
	parameter int unsigned HEIGHT_LINES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lcdfb_pkg::op_t           head,
	input  wire lcdfb_pkg::queue_status_t q_status,
	output logic                          pop,
	lcdfb_stream_if.source                result
);

	localparam int unsigned BPL   = WIDTH_PIXELS / 8;
	localparam int unsigned DEPTH = BPL * HEIGHT_LINES;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned ROW_W = (HEIGHT_LINES > 1) ? $clog2(HEIGHT_LINES) : 1;
	localparam logic [lcdfb_pkg::COL_MAX_W-1:0] COL_LAST =
		lcdfb_pkg::COL_MAX_W'(BPL - 1);

	lcdfb_pkg::back_state_t state_q;
	lcdfb_pkg::back_state_t state_d;

	// Frame memory; a row whose valid bit is low reads as blank
	logic [7:0]              mem_q [DEPTH];
	logic [7:0]              rd_data_q;
	logic [HEIGHT_LINES-1:0] row_valid_q;

	logic [lcdfb_pkg::COL_MAX_W-1:0]  cnt_q;
	lcdfb_pkg::result_item_t          res_q;
	logic                             res_valid_q;

	logic                             slot_free;
	logic                             row_ok;
	logic [lcdfb_pkg::ADDR_MAX_W-1:0] pix_addr;
	logic [lcdfb_pkg::ADDR_MAX_W-1:0] line_addr;
	logic                             last_col;
	logic [7:0]                       line_byte;

	logic                             emit;
	lcdfb_pkg::result_item_t          emit_item;
	logic                             mem_re;
	logic [lcdfb_pkg::ADDR_MAX_W-1:0] mem_raddr;
	logic                             mem_we;
	logic [lcdfb_pkg::ADDR_MAX_W-1:0] mem_waddr;
	logic [7:0]                       mem_wdata;
	logic                             cnt_clr;
	logic                             cnt_inc;
	logic                             row_set;
	logic                             valid_clr_all;

	assign slot_free = !res_valid_q || result.ready;
	assign row_ok    = row_valid_q[head.row[ROW_W-1:0]];
	assign pix_addr  = head.base + lcdfb_pkg::ADDR_MAX_W'(head.col);
	assign line_addr = head.base + lcdfb_pkg::ADDR_MAX_W'(cnt_q);
	assign last_col  = cnt_q == COL_LAST;
	assign line_byte = row_ok ? rd_data_q : lcdfb_pkg::BYTE_BLANK;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcdfb_pkg::ST_IDLE: begin
				if (q_status.not_empty) begin
					unique case (head.command)
						lcdfb_pkg::CMD_WRITE_PIXEL: begin
							state_d = row_ok ? lcdfb_pkg::ST_WR_MERGE : lcdfb_pkg::ST_ROW_INIT;
						end
						lcdfb_pkg::CMD_READ_PIXEL: begin
							if (head.in_range && row_ok) begin
								state_d = lcdfb_pkg::ST_READ_EMIT;
							end
						end
						lcdfb_pkg::CMD_CLEAR_DISPLAY: begin
							if (slot_free) begin
								state_d = lcdfb_pkg::ST_CLEAR_TAIL;
							end
						end
						lcdfb_pkg::CMD_SEND_LINE: begin
							if (slot_free) begin
								state_d = lcdfb_pkg::ST_LINE_READ;
							end
						end
						default: ;
					endcase
				end
			end
			lcdfb_pkg::ST_WR_MERGE: state_d = lcdfb_pkg::ST_IDLE;
			lcdfb_pkg::ST_ROW_INIT: begin
				if (last_col) begin
					state_d = lcdfb_pkg::ST_IDLE;
				end
			end
			lcdfb_pkg::ST_READ_EMIT, lcdfb_pkg::ST_CLEAR_TAIL, lcdfb_pkg::ST_LINE_TAIL: begin
				if (slot_free) begin
					state_d = lcdfb_pkg::ST_IDLE;
				end
			end
			lcdfb_pkg::ST_LINE_READ: state_d = lcdfb_pkg::ST_LINE_EMIT;
			lcdfb_pkg::ST_LINE_EMIT: begin
				if (slot_free) begin
					state_d = last_col ? lcdfb_pkg::ST_LINE_TAIL : lcdfb_pkg::ST_LINE_READ;
				end
			end
			default: state_d = lcdfb_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		emit          = 1'b0;
		emit_item     = '0;
		pop           = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = pix_addr;
		mem_we        = 1'b0;
		mem_waddr     = pix_addr;
		mem_wdata     = lcdfb_pkg::merge_bit(rd_data_q, head.bit_idx, head.value);
		cnt_clr       = 1'b0;
		cnt_inc       = 1'b0;
		row_set       = 1'b0;
		valid_clr_all = 1'b0;
		unique case (state_q)
			lcdfb_pkg::ST_IDLE: begin
				if (q_status.not_empty) begin
					unique case (head.command)
						lcdfb_pkg::CMD_WRITE_PIXEL: begin
							mem_re  = row_ok;
							cnt_clr = 1'b1;
						end
						lcdfb_pkg::CMD_READ_PIXEL: begin
							if (head.in_range && row_ok) begin
								mem_re = 1'b1;
							end else if (slot_free) begin
								// Blank row reads as one, out of range as zero
								emit      = 1'b1;
								emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_PIXEL,
									8'h00, head.in_range, 1'b1);
								pop       = 1'b1;
							end
						end
						lcdfb_pkg::CMD_FILL: begin
							valid_clr_all = 1'b1;
							pop           = 1'b1;
						end
						lcdfb_pkg::CMD_CLEAR_DISPLAY: begin
							if (slot_free) begin
								valid_clr_all = 1'b1;
								emit          = 1'b1;
								emit_item     = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK,
									lcdfb_pkg::BYTE_CLEAR, 1'b0, 1'b0);
							end
						end
						lcdfb_pkg::CMD_BEGIN_WRITE: begin
							if (slot_free) begin
								emit      = 1'b1;
								emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK,
									lcdfb_pkg::BYTE_BEGIN_WRITE, 1'b0, 1'b1);
								pop       = 1'b1;
							end
						end
						lcdfb_pkg::CMD_SEND_LINE: begin
							if (slot_free) begin
								emit      = 1'b1;
								emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK,
									head.row + 8'd1, 1'b0, 1'b0);
								cnt_clr   = 1'b1;
							end
						end
						lcdfb_pkg::CMD_END_WRITE: begin
							if (slot_free) begin
								emit      = 1'b1;
								emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK,
									lcdfb_pkg::BYTE_TRAILER, 1'b0, 1'b1);
								pop       = 1'b1;
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			lcdfb_pkg::ST_WR_MERGE: begin
				mem_we = 1'b1;
				pop    = 1'b1;
			end
			lcdfb_pkg::ST_ROW_INIT: begin
				// Blank the whole row, merging the pixel into its byte
				mem_we    = 1'b1;
				mem_waddr = line_addr;
				mem_wdata = (cnt_q == head.col) ?
					lcdfb_pkg::merge_bit(lcdfb_pkg::BYTE_BLANK, head.bit_idx, head.value) :
					lcdfb_pkg::BYTE_BLANK;
				cnt_inc   = 1'b1;
				if (last_col) begin
					row_set = 1'b1;
					pop     = 1'b1;
				end
			end
			lcdfb_pkg::ST_READ_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_PIXEL, 8'h00,
						rd_data_q[head.bit_idx], 1'b1);
					pop       = 1'b1;
				end
			end
			lcdfb_pkg::ST_CLEAR_TAIL, lcdfb_pkg::ST_LINE_TAIL: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK,
						lcdfb_pkg::BYTE_TRAILER, 1'b0, 1'b1);
					pop       = 1'b1;
				end
			end
			lcdfb_pkg::ST_LINE_READ: begin
				mem_re    = 1'b1;
				mem_raddr = line_addr;
			end
			lcdfb_pkg::ST_LINE_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_item = lcdfb_pkg::make_result(lcdfb_pkg::KIND_LINK, line_byte,
						1'b0, 1'b0);
					cnt_inc   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcdfb_pkg::ST_IDLE;
			row_valid_q <= '0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (valid_clr_all) begin
				row_valid_q <= '0;
			end else if (row_set) begin
				row_valid_q[head.row[ROW_W-1:0]] <= 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_item;
		end
	end

	// Frame memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr[AW-1:0]] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr[AW-1:0]];
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/memory_lcd_frame_buffer_refresh.sv =====
// ----------------------------------------------------------------------------
// memory_lcd_frame_buffer_refresh
// One-bit-per-pixel frame store and serial byte source for a memory LCD.
// ----------------------------------------------------------------------------
// Commands enter through a one-stage front end that range-checks them, drops
// out-of-range writes, out-of-range line sends and unused codes, computes the
// row base address and queues the operation in a two-entry queue. The back end
// runs one operation at a time on a frame memory with one write port and a
// registered read port: write pixel reads the byte, then merge-writes it,
// except the first write to a row after reset, a fill or a clear display,
// which blanks the whole row; read pixel reads the byte, then answers, at
// once when the row is blank or the pixel is out of range; fill resets the
// row valid bits; begin, end and clear send their link bytes; send line
// reads each line byte before it sends it. The front end registers each
// command. Reset, fill and clear display reset per-row valid bits at once,
// so there is no clearing pass. Results leave through an output register
// that takes a new byte while the previous one is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_lcd_frame_buffer_refresh #(
	parameter int unsigned WIDTH_PIXELS = 320,
	parameter int unsigned HEIGHT_LINES = 240
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lcdfb_stream_if.sink    cmd,
	lcdfb_stream_if.source  result
);

	lcdfb_pkg::op_t           push_op;
	lcdfb_pkg::op_t           head;
	lcdfb_pkg::queue_status_t q_status;
	logic                     push;
	logic                     pop;

	lcdfb_front #(
		.WIDTH_PIXELS(WIDTH_PIXELS),
		.HEIGHT_LINES(HEIGHT_LINES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.push_op  (push_op),
		.push     (push),
		.q_status (q_status)
	);

	lcdfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	lcdfb_back #(
		.WIDTH_PIXELS(WIDTH_PIXELS),
		.HEIGHT_LINES(HEIGHT_LINES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	// Front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("operation pushed into full queue");

	// Back end never retires an operation that is not there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.not_empty)
		else $error("operation popped from empty queue");

	// A pixel answer is a single result with no link byte
	a_pixel_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.data.result_kind == lcdfb_pkg::KIND_PIXEL)) |->
		(result.data.last && (result.data.out_byte == 8'h00)))
		else $error("malformed pixel read answer");
`endif

endmodule

`default_nettype wire

// ===== bench/memory_lcd_frame_buffer_refresh_tb.sv =====
// ----------------------------------------------------------------------------
// memory_lcd_frame_buffer_refresh_tb
// Self-checking bench for the memory LCD frame buffer. A shadow frame store
// predicts every pixel answer and every link byte. A directed pass covers the
// range edges and each command. Random traffic follows, mostly frame refresh
// sequences and pixel edits on a few busy rows. Both channels stall at random.
// ----------------------------------------------------------------------------

module memory_lcd_frame_buffer_refresh_tb;

	localparam int unsigned WIDTH_PIXELS = 320;
	localparam int unsigned HEIGHT_LINES = 240;
	localparam int unsigned LINE_BYTES   = WIDTH_PIXELS / 8;
	localparam int unsigned STORE_BYTES  = HEIGHT_LINES * LINE_BYTES;

	// Code outside the command enum; the block drops it
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	// Settle window after the last result: covers a blank-row write or a line send
	localparam int unsigned QUIET_CYCLES = 200;

	// Shadow frame store plus the results still owed by the block
	class lcd_frame_tracker;
		logic [7:0]              frame [STORE_BYTES];
		lcdfb_pkg::result_item_t awaited_results [$];
		int unsigned             errors;

		function new();
			errors = 0;
			blank_frame();
		endfunction

		function void blank_frame();
			foreach (frame[i]) frame[i] = lcdfb_pkg::BYTE_BLANK;
		endfunction

		function void add(logic kind, logic [7:0] data_byte, logic pix);
			lcdfb_pkg::result_item_t r;
			r.result_kind      = kind;
			r.out_byte         = data_byte;
			r.read_pixel_value = pix;
			r.last             = 1'b0;
			awaited_results.push_back(r);
		endfunction

		// Apply one accepted command to the shadow store and queue its results
		function void note_command(lcdfb_pkg::cmd_item_t item);
			int unsigned before_cnt;
			int unsigned addr;
			logic        in_range;
			before_cnt = awaited_results.size();
			in_range   = (item.x_pos < WIDTH_PIXELS) && (item.x_pos / 8 < LINE_BYTES) &&
				(item.y_pos < HEIGHT_LINES);
			addr       = item.y_pos * LINE_BYTES + item.x_pos / 8;
			case (item.command)
				lcdfb_pkg::CMD_WRITE_PIXEL: begin
					if (in_range)
						frame[addr][item.x_pos[2:0]] = item.pixel_value;
				end
				lcdfb_pkg::CMD_READ_PIXEL: begin
					add(lcdfb_pkg::KIND_PIXEL, 8'h00,
						in_range ? frame[addr][item.x_pos[2:0]] : 1'b0);
				end
				lcdfb_pkg::CMD_FILL: begin
					blank_frame();
				end
				lcdfb_pkg::CMD_CLEAR_DISPLAY: begin
					blank_frame();
					add(lcdfb_pkg::KIND_LINK, lcdfb_pkg::BYTE_CLEAR, 1'b0);
					add(lcdfb_pkg::KIND_LINK, lcdfb_pkg::BYTE_TRAILER, 1'b0);
				end
				lcdfb_pkg::CMD_BEGIN_WRITE: begin
					add(lcdfb_pkg::KIND_LINK, lcdfb_pkg::BYTE_BEGIN_WRITE, 1'b0);
				end
				lcdfb_pkg::CMD_SEND_LINE: begin
					// line number is sent one-based, then the row, then a trailer
					if (item.y_pos < HEIGHT_LINES) begin
						add(lcdfb_pkg::KIND_LINK, 8'(item.y_pos + 10'd1), 1'b0);
						for (int i = 0; i < LINE_BYTES; i++)
							add(lcdfb_pkg::KIND_LINK, frame[item.y_pos * LINE_BYTES + i], 1'b0);
						add(lcdfb_pkg::KIND_LINK, lcdfb_pkg::BYTE_TRAILER, 1'b0);
					end
				end
				lcdfb_pkg::CMD_END_WRITE: begin
					add(lcdfb_pkg::KIND_LINK, lcdfb_pkg::BYTE_TRAILER, 1'b0);
				end
				default: begin
				end
			endcase
			if (awaited_results.size() > before_cnt)
				awaited_results[awaited_results.size() - 1].last = 1'b1;
		endfunction

		// Compare one result transfer with the oldest owed result
		function void check_result(lcdfb_pkg::result_item_t got);
			lcdfb_pkg::result_item_t want;
			if (awaited_results.size() == 0) begin
				$error("unexpected result: result_kind %0d out_byte %02h read_pixel_value %0d last %0d",
					got.result_kind, got.out_byte, got.read_pixel_value, got.last);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
				errors++;
			end
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.read_pixel_value !== want.read_pixel_value) begin
				$error("read_pixel_value: expected %0d, actual %0d",
					want.read_pixel_value, got.read_pixel_value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 85;

	lcd_frame_tracker tracker = new();

	lcdfb_stream_if #(.data_t(lcdfb_pkg::cmd_item_t))    cmd_if ();
	lcdfb_stream_if #(.data_t(lcdfb_pkg::result_item_t)) result_if ();

	memory_lcd_frame_buffer_refresh #(
		.WIDTH_PIXELS(WIDTH_PIXELS),
		.HEIGHT_LINES(HEIGHT_LINES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.result(result_if)
	);

	always #5 clk = ~clk;

	// Result side back-pressure, changed on the falling edge
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			tracker.check_result(result_if.data);
	end

	function automatic lcdfb_pkg::cmd_item_t mk(input logic [2:0] code, input int unsigned x,
		input int unsigned y, input bit v);
		lcdfb_pkg::cmd_item_t it;
		it.command     = code;
		it.x_pos       = 10'(x);
		it.y_pos       = 10'(y);
		it.pixel_value = v;
		return it;
	endfunction

	// Random pixel value
	function automatic bit pick_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Mostly columns on the panel, sometimes anywhere in the field
	function automatic int unsigned pick_col();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, WIDTH_PIXELS - 1);
		return $urandom_range(0, 1023);
	endfunction

	// Mostly a few busy rows so that line sends show edited content
	function automatic int unsigned pick_row();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: return 0;
				1: return 1;
				2: return 119;
				default: return HEIGHT_LINES - 1;
			endcase
		end
		if (r < 90)
			return $urandom_range(0, HEIGHT_LINES - 1);
		return $urandom_range(0, 1023);
	endfunction

	// One command transfer; entered and left at a falling edge
	task automatic send_cmd(input lcdfb_pkg::cmd_item_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= item;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		tracker.note_command(item);
		@(negedge clk);
	endtask

	// Hold the command side until every owed result has arrived
	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 0, 0, 1'b0));        // untouched row reads blank
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, 0, 0, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 0, 0, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, WIDTH_PIXELS - 1, HEIGHT_LINES - 1, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, WIDTH_PIXELS - 1, HEIGHT_LINES - 1, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, WIDTH_PIXELS - 2, HEIGHT_LINES - 1, 1'b0));
		// pixels off the panel: writes dropped, reads answer zero
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, WIDTH_PIXELS, 5, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, 5, HEIGHT_LINES, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, WIDTH_PIXELS, 5, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 5, HEIGHT_LINES, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 1023, 1023, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, 7, 0, 1'b1));
		// a refresh sequence, with lines past the panel producing nothing
		send_cmd(mk(lcdfb_pkg::CMD_BEGIN_WRITE, 1023, 1023, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_SEND_LINE, 0, 0, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_SEND_LINE, 1023, HEIGHT_LINES - 1, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_SEND_LINE, 0, HEIGHT_LINES, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_SEND_LINE, 0, 1023, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_END_WRITE, 0, 0, 1'b0));
		send_cmd(mk(CMD_UNUSED, 1023, 1023, 1'b1));
		send_cmd(mk(lcdfb_pkg::CMD_FILL, 0, 0, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 0, 0, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_WRITE_PIXEL, 100, 100, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_CLEAR_DISPLAY, 0, 0, 1'b0));
		send_cmd(mk(lcdfb_pkg::CMD_READ_PIXEL, 100, 100, 1'b0));
	endtask

	// Random traffic; outside refresh sequences, dropped commands do not count toward the quota
	task automatic run_random(input int unsigned quota);
		int unsigned          done_cnt;
		int unsigned          r;
		int unsigned          lines;
		lcdfb_pkg::cmd_item_t it;
		done_cnt = 0;
		while (done_cnt < quota) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				// refresh sequence: begin, a few lines, end
				lines = $urandom_range(1, 3);
				send_cmd(mk(lcdfb_pkg::CMD_BEGIN_WRITE, $urandom_range(0, 1023),
					$urandom_range(0, 1023), pick_bit()));
				repeat (lines)
					send_cmd(mk(lcdfb_pkg::CMD_SEND_LINE, $urandom_range(0, 1023), pick_row(),
						pick_bit()));
				send_cmd(mk(lcdfb_pkg::CMD_END_WRITE, $urandom_range(0, 1023),
					$urandom_range(0, 1023), pick_bit()));
				done_cnt += lines + 2;
			end else begin
				if (r < 55)
					it = mk(lcdfb_pkg::CMD_WRITE_PIXEL, pick_col(), pick_row(), pick_bit());
				else if (r < 75)
					it = mk(lcdfb_pkg::CMD_READ_PIXEL, pick_col(), pick_row(), pick_bit());
				else if (r < 83)
					it = mk(lcdfb_pkg::CMD_SEND_LINE, $urandom_range(0, 1023), pick_row(),
						pick_bit());
				else if (r < 86)
					it = mk(lcdfb_pkg::CMD_FILL, $urandom_range(0, 1023),
						$urandom_range(0, 1023), pick_bit());
				else if (r < 89)
					it = mk(lcdfb_pkg::CMD_CLEAR_DISPLAY, $urandom_range(0, 1023),
						$urandom_range(0, 1023), pick_bit());
				else if (r < 93)
					it = mk(lcdfb_pkg::CMD_BEGIN_WRITE, $urandom_range(0, 1023),
						$urandom_range(0, 1023), pick_bit());
				else if (r < 97)
					it = mk(lcdfb_pkg::CMD_END_WRITE, $urandom_range(0, 1023),
						$urandom_range(0, 1023), pick_bit());
				else
					it = mk(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
						pick_bit());
				send_cmd(it);
				if (!(it.command == CMD_UNUSED ||
					(it.command == lcdfb_pkg::CMD_WRITE_PIXEL &&
						(it.x_pos >= WIDTH_PIXELS || it.y_pos >= HEIGHT_LINES)) ||
					(it.command == lcdfb_pkg::CMD_SEND_LINE && it.y_pos >= HEIGHT_LINES)))
					done_cnt++;
			end
		end
	endtask

	// Main sequence
	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		drain();
		run_random(100);
		drain();

		send_idle_pct = 85;
		recv_idle_pct = 23;
		run_random(100);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(100);
		drain();

		if (tracker.errors == 0)
			$display("memory_lcd_frame_buffer_refresh_tb passed");
		else
			$display("memory_lcd_frame_buffer_refresh_tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("memory_lcd_frame_buffer_refresh_tb failed");
		$finish;
	end

endmodule
